>>> src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset
`define BPA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Condition that must never be true outside reset
`define BPA_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

>>> src/bpa_pkg.sv
package bpa_pkg;

    // default geometry of the page bitmap
    localparam int PAGE_LIMIT_DEF    = 1024;
    localparam int MAP_WORD_BITS_DEF = 32;

    // fixed field widths on the stream ports
    localparam int PAGE_IDX_W = 10;
    localparam int PAGE_CNT_W = 11;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 2;
    localparam int S_DATA_W   = 16;
    localparam int M_DATA_W   = 24;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_CHECK,
        OP_MARK
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_FREE_ERR,
        ST_FULL,
        ST_NOT_FOUND
    } t_status;

endpackage

>>> src/bpa_map_mem.sv
// Bitmap word store: one write and one registered read per cycle.
// Per-word valid bits make every word read as zero until first written.
module bpa_map_mem #(
    parameter int WORDS     = 32,
    parameter int WORD_BITS = 32,
    parameter int ADDR_W    = 5
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [ADDR_W-1:0]    i_rd_addr,
    output logic [WORD_BITS-1:0] o_rd_word,
    input  logic                 i_wr_en,
    input  logic [ADDR_W-1:0]    i_wr_addr,
    input  logic [WORD_BITS-1:0] i_wr_data
);

    logic [WORD_BITS-1:0] mem [WORDS];
    logic [WORDS-1:0]     r_valid;
    logic [WORD_BITS-1:0] r_rdata;
    logic                 r_rd_vld;

    // storage array
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rdata <= mem[i_rd_addr];
        end
    end

    // written-word flags, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_word = r_rd_vld ? r_rdata : '0;

endmodule

>>> src/bitmap_page_allocator_unit.sv
// Path from accepted word to result word: check and mark go straight to the result state,
// free reads its bitmap word first, and allocate scans one bitmap word per cycle until a free page.
// Throughput: one request at a time, next accepted the cycle after the result is staged;
// allocate scan over the bitmap RAM read port sets the worst case.
// Reset (synchronous, active low) frees every page and clears the page count at once.
`include "assert_macros.svh"

module bitmap_page_allocator_unit #(
    parameter int PAGE_LIMIT    = bpa_pkg::PAGE_LIMIT_DEF,    // 32..1024
    parameter int MAP_WORD_BITS = bpa_pkg::MAP_WORD_BITS_DEF  // power of two, 8..64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [bpa_pkg::S_DATA_W-1:0]  i_s_tdata,   // [9:0] page_index, rest zero
    input  logic [bpa_pkg::OP_W-1:0]      i_s_tuser,   // [1:0] op
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [bpa_pkg::M_DATA_W-1:0]  o_m_tdata,   // [9:0] granted_page,
                                                       // [20:10] page_count, rest zero
    output logic [bpa_pkg::STATUS_W-1:0]  o_m_tuser    // [1:0] status
);

    localparam int MAP_WORDS = (PAGE_LIMIT + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WA_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(MAP_WORD_BITS);
    localparam int CNT_W     = $clog2(PAGE_LIMIT + 1);
    localparam int CMP_W     = ((CNT_W > bpa_pkg::PAGE_IDX_W) ? CNT_W
                                                             : bpa_pkg::PAGE_IDX_W) + 1;
    localparam int LAST_FILL = PAGE_LIMIT - (MAP_WORDS - 1) * MAP_WORD_BITS;
    localparam logic [WA_W-1:0]          LAST_WORD = WA_W'(MAP_WORDS - 1);
    localparam logic [CMP_W-1:0]         LIMIT_C   = CMP_W'(PAGE_LIMIT);
    // bits of the last word past the page limit count as taken
    localparam logic [MAP_WORD_BITS-1:0] PAD_LAST  =
        ~({MAP_WORD_BITS{1'b1}} >> (MAP_WORD_BITS - LAST_FILL));

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALLOC,
        S_FREE,
        S_RESP
    } t_state;

    t_state                              r_state;
    logic [bpa_pkg::PAGE_IDX_W-1:0]      r_pg;
    logic [WA_W-1:0]                     r_addr;
    logic [CNT_W-1:0]                    r_hw;
    bpa_pkg::t_status                    r_res_status;
    logic [bpa_pkg::PAGE_IDX_W-1:0]      r_res_grant;
    logic                                r_m_valid;
    bpa_pkg::t_status                    r_m_status;
    logic [bpa_pkg::PAGE_IDX_W-1:0]      r_m_grant;
    logic [bpa_pkg::PAGE_CNT_W-1:0]      r_m_count;

    logic                                s_fire;
    bpa_pkg::t_op                        in_op;
    logic [CMP_W-1:0]                    in_pg_ext;
    logic [WA_W-1:0]                     in_word;
    logic                                in_free_ok;
    logic [CMP_W-1:0]                    in_pg_inc;
    logic [CMP_W-1:0]                    mark_need;
    logic [CMP_W-1:0]                    hw_ext;

    logic [MAP_WORD_BITS-1:0]            rd_word;
    logic [MAP_WORD_BITS-1:0]            pad_mask;
    logic [MAP_WORD_BITS-1:0]            free_bits;
    logic [BIT_W-1:0]                    low_bit;
    logic                                found;
    logic                                last;
    logic [CMP_W-1:0]                    grant_ext;
    logic [CMP_W-1:0]                    alloc_need;
    logic [MAP_WORD_BITS-1:0]            free_mask;
    logic                                free_set;

    logic                                rd_en;
    logic [WA_W-1:0]                     rd_addr;
    logic                                wr_en;
    logic [MAP_WORD_BITS-1:0]            wr_data;

    // input decode
    assign o_s_tready = (r_state == S_IDLE);
    assign s_fire     = i_s_tvalid && o_s_tready;
    assign in_op      = bpa_pkg::t_op'(i_s_tuser);
    assign in_pg_ext  = CMP_W'(i_s_tdata[bpa_pkg::PAGE_IDX_W-1:0]);
    assign in_word    = WA_W'(in_pg_ext >> BIT_W);
    assign in_free_ok = (in_pg_ext < LIMIT_C);
    assign in_pg_inc  = in_pg_ext + CMP_W'(1);
    assign mark_need  = (in_pg_inc > LIMIT_C) ? LIMIT_C : in_pg_inc;
    assign hw_ext     = CMP_W'(r_hw);

    // lowest clear bit of the word under scan
    assign pad_mask  = (r_addr == LAST_WORD) ? PAD_LAST : '0;
    assign free_bits = ~(rd_word | pad_mask);
    assign found     = |free_bits;
    assign last      = (r_addr == LAST_WORD);

    always_comb begin
        low_bit = '0;
        for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
            if (free_bits[i]) begin
                low_bit = BIT_W'(i);
            end
        end
    end

    assign grant_ext  = CMP_W'({r_addr, low_bit});
    assign alloc_need = grant_ext + CMP_W'(1);

    // bit under test for free
    assign free_mask = MAP_WORD_BITS'(1) << r_pg[BIT_W-1:0];
    assign free_set  = |(rd_word & free_mask);

    // bitmap RAM access
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_data = rd_word | (MAP_WORD_BITS'(1) << low_bit);
        case (r_state)
            S_IDLE: begin
                if (s_fire && in_op == bpa_pkg::OP_ALLOC) begin
                    rd_en = 1'b1;
                end else if (s_fire && in_op == bpa_pkg::OP_FREE && in_free_ok) begin
                    rd_en   = 1'b1;
                    rd_addr = in_word;
                end
            end
            S_ALLOC: begin
                if (found) begin
                    wr_en = 1'b1;
                end else if (!last) begin
                    rd_en   = 1'b1;
                    rd_addr = r_addr + WA_W'(1);
                end
            end
            S_FREE: begin
                wr_en   = free_set;
                wr_data = rd_word & ~free_mask;
            end
            default: begin
            end
        endcase
    end

    bpa_map_mem #(
        .WORDS     (MAP_WORDS),
        .WORD_BITS (MAP_WORD_BITS),
        .ADDR_W    (WA_W)
    ) u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_word (rd_word),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_addr),
        .i_wr_data (wr_data)
    );

    // request sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_hw      <= '0;
            r_m_valid <= 1'b0;
        end else begin
            // output word flag: set when a result is staged, cleared when taken
            if (r_state == S_RESP && (!r_m_valid || i_m_tready)) begin
                r_m_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_fire) begin
                        r_pg        <= i_s_tdata[bpa_pkg::PAGE_IDX_W-1:0];
                        r_res_grant <= '0;
                        case (in_op)
                            bpa_pkg::OP_ALLOC: begin
                                r_addr  <= '0;
                                r_state <= S_ALLOC;
                            end
                            bpa_pkg::OP_FREE: begin
                                r_addr <= in_word;
                                if (in_free_ok) begin
                                    r_state <= S_FREE;
                                end else begin
                                    r_res_status <= bpa_pkg::ST_FREE_ERR;
                                    r_state      <= S_RESP;
                                end
                            end
                            bpa_pkg::OP_CHECK: begin
                                r_res_status <= (in_pg_ext >= hw_ext) ?
                                                bpa_pkg::ST_NOT_FOUND : bpa_pkg::ST_OK;
                                r_state      <= S_RESP;
                            end
                            bpa_pkg::OP_MARK: begin
                                if (mark_need > hw_ext) begin
                                    r_hw <= CNT_W'(mark_need);
                                end
                                r_res_status <= bpa_pkg::ST_OK;
                                r_state      <= S_RESP;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_ALLOC: begin
                    if (found) begin
                        r_res_status <= bpa_pkg::ST_OK;
                        r_res_grant  <= bpa_pkg::PAGE_IDX_W'(grant_ext);
                        if (alloc_need > hw_ext) begin
                            r_hw <= CNT_W'(alloc_need);
                        end
                        r_state <= S_RESP;
                    end else if (last) begin
                        r_res_status <= bpa_pkg::ST_FULL;
                        r_state      <= S_RESP;
                    end else begin
                        r_addr <= r_addr + WA_W'(1);
                    end
                end
                S_FREE: begin
                    r_res_status <= free_set ? bpa_pkg::ST_OK : bpa_pkg::ST_FREE_ERR;
                    r_state      <= S_RESP;
                end
                S_RESP: begin
                    if (!r_m_valid || i_m_tready) begin
                        r_m_status <= r_res_status;
                        r_m_grant  <= r_res_grant;
                        r_m_count  <= bpa_pkg::PAGE_CNT_W'(r_hw);
                        r_state    <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tuser  = r_m_status;
    assign o_m_tdata  = bpa_pkg::M_DATA_W'({r_m_count, r_m_grant});

    // checks
    `BPA_ASSERT_NEVER(a_rw_clash, i_clk, i_rst_n, rd_en && wr_en, "bitmap read and write overlap")
    `BPA_ASSERT(a_hw_limit, i_clk, i_rst_n, hw_ext <= LIMIT_C, "page count above limit")
    `BPA_ASSERT(a_hw_rise, i_clk, i_rst_n, 1'b1 |=> r_hw >= $past(r_hw), "page count fell")
    `BPA_ASSERT(a_resp_load, i_clk, i_rst_n,
                (r_state == S_RESP && !r_m_valid) |=> (r_m_valid && r_state == S_IDLE),
                "result not staged")

endmodule
